FILE: design/sslp_pkg.sv
// sslp_pkg: shared types and constants for the servo slew-limited PWM block.
// Used by sslp_ctrl, sslp_datapath and servo_slew_limited_pwm_top.
// No dependencies.
`timescale 1ns / 1ps

package sslp_pkg;

  // Item opcodes
  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_PULSE_GAIN = 2'd0;
  localparam logic [1:0] CFG_PULSE_MID  = 2'd1;
  localparam logic [1:0] CFG_CHAN_USE   = 2'd2;

  // Configuration reset values
  localparam logic [11:0] GAIN_RST     = 12'd800;
  localparam logic [11:0] MID_RST      = 12'd2040;
  localparam logic [2:0]  CHAN_USE_RST = 3'd5;

  // Arithmetic constants
  localparam int          PIN_BITS   = 5;
  localparam logic signed [11:0] TARGET_MAX = 12'sd1024;
  localparam logic signed [11:0] TARGET_MIN = -12'sd1024;
  localparam logic signed [18:0] POS_SCALE  = 19'sd100;
  // ceil(2^24 / 100): |pos| * RECIP_100 >> 24 == |pos| / 100 for |pos| < 2^17
  localparam logic [17:0] RECIP_100  = 18'd167773;
  localparam int          RECIP_SHIFT = 24;
  localparam logic signed [14:0] PWM_MIN = 15'sd200;
  localparam logic signed [14:0] PWM_MAX = 15'sd3250;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_SCALE,
    ST_GAIN,
    ST_FIN,
    ST_OUT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic set_wr;     // store a set item
    logic tick_load;  // capture pin levels of a tick item
    logic step;       // settle enable and move current channel
    logic scale;      // position / 100
    logic gain;       // quotient * gain
    logic finish;     // midpoint, clamp, load result register
    logic last;       // current channel is the last of this tick
  } cmd_t;

endpackage

FILE: design/sslp_ctrl.sv
// sslp_ctrl: sequencer that walks the served channels of a tick item.
// Depends on sslp_pkg; drives sslp_datapath through sslp_pkg::cmd_t.
`timescale 1ns / 1ps

module sslp_ctrl #(
  parameter int CHANNELS = 5,
  parameter int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  parameter int NW = $clog2(CHANNELS + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_op,
  output logic           out_valid,
  input  logic           out_ready,
  input  logic [NW-1:0]  n_eff,
  output logic [CW-1:0]  chan_idx,
  output sslp_pkg::cmd_t cmd
);

  sslp_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          accept;
  logic          is_last;

  assign chan_idx = idx_r;
  assign accept   = in_valid && in_ready;
  assign is_last  = (NW'(idx_r) + NW'(1)) == n_eff;

  // State and channel counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sslp_pkg::ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd           = '0;
    cmd.last      = is_last;
    unique case (state_r)
      sslp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (in_op == sslp_pkg::OP_SET) begin
            cmd.set_wr = 1'b1;
          end else begin
            cmd.tick_load = 1'b1;
            idx_nxt       = '0;
            if (n_eff != '0) begin
              state_nxt = sslp_pkg::ST_STEP;
            end
          end
        end
      end
      sslp_pkg::ST_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = sslp_pkg::ST_SCALE;
      end
      sslp_pkg::ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = sslp_pkg::ST_GAIN;
      end
      sslp_pkg::ST_GAIN: begin
        cmd.gain  = 1'b1;
        state_nxt = sslp_pkg::ST_FIN;
      end
      sslp_pkg::ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = sslp_pkg::ST_OUT;
      end
      sslp_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (is_last) begin
            state_nxt = sslp_pkg::ST_IDLE;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = sslp_pkg::ST_STEP;
          end
        end
      end
      default: begin
        state_nxt = sslp_pkg::ST_IDLE;
      end
    endcase
  end

  // Input and output sides never open together
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  // Served channel stays inside the tick's channel count
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != sslp_pkg::ST_IDLE) |-> (NW'(idx_r) < n_eff))
    else $error("channel counter beyond channels in use");

  // A tick with no channels in use returns straight to idle
  a_empty_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == sslp_pkg::OP_TICK && n_eff == '0)
      |=> (state_r == sslp_pkg::ST_IDLE))
    else $error("empty tick started a channel walk");

  // Last result of a tick returns to idle
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && is_last) |=> in_ready)
    else $error("tick did not finish after its last result");

endmodule

FILE: design/sslp_datapath.sv
// sslp_datapath: channel state, configuration registers, ramp step and PWM math.
// Depends on sslp_pkg; sequenced by sslp_ctrl.
`timescale 1ns / 1ps

module sslp_datapath #(
  parameter int CHANNELS = 5,
  parameter int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  parameter int NW = $clog2(CHANNELS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sslp_pkg::cmd_t     cmd,
  input  logic [CW-1:0]      chan_idx,
  output logic [NW-1:0]      n_eff,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_wdata,
  input  logic [2:0]         in_channel,
  input  logic signed [11:0] in_target_pos,
  input  logic [11:0]        in_step_limit,
  input  logic               in_enable_req,
  input  logic [4:0]         in_pins_low,
  output logic [2:0]         out_channel,
  output logic               out_pwm_write,
  output logic [11:0]        out_pwm_value,
  output logic               out_last
);

  // Configuration
  logic [11:0] gain_r;
  logic [11:0] mid_r;
  logic [2:0]  chan_use_r;

  // Per-channel state
  logic                     enabled_r [CHANNELS];
  logic                     request_r [CHANNELS];
  logic signed [11:0]       target_r  [CHANNELS];
  logic [11:0]              rate_r    [CHANNELS];
  logic signed [17:0]       pos_r     [CHANNELS];

  logic [4:0] pins_r;

  // Step results and PWM pipeline
  logic               wr_r;
  logic               calc_r;
  logic signed [17:0] pos_s_r;
  logic               neg_r;
  logic [34:0]        prod1_r;
  logic [22:0]        prod2_r;

  // Combinational step
  logic               pin_low;
  logic               en_new;
  logic               wr_c;
  logic               calc_c;
  logic signed [17:0] pos_new;
  logic signed [18:0] err;
  logic signed [18:0] mag;
  logic signed [18:0] dw;
  logic signed [18:0] rate_ext;
  logic signed [11:0] tgt_sat;
  logic [16:0]        abs_pos;
  logic [10:0]        quot;
  logic [12:0]        mag_pwm;
  logic signed [14:0] pwm_raw;
  logic [11:0]        pwm_clamped;

  // Channels in use, saturated to the built channel count
  always_comb begin
    if (int'(chan_use_r) > CHANNELS) begin
      n_eff = NW'(CHANNELS);
    end else begin
      n_eff = NW'(chan_use_r);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r     <= sslp_pkg::GAIN_RST;
      mid_r      <= sslp_pkg::MID_RST;
      chan_use_r <= sslp_pkg::CHAN_USE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sslp_pkg::CFG_PULSE_GAIN: gain_r     <= cfg_wdata;
        sslp_pkg::CFG_PULSE_MID:  mid_r      <= cfg_wdata;
        sslp_pkg::CFG_CHAN_USE:   chan_use_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Target saturation for set items
  always_comb begin
    if (in_target_pos > sslp_pkg::TARGET_MAX) begin
      tgt_sat = sslp_pkg::TARGET_MAX;
    end else if (in_target_pos < sslp_pkg::TARGET_MIN) begin
      tgt_sat = sslp_pkg::TARGET_MIN;
    end else begin
      tgt_sat = in_target_pos;
    end
  end

  // Enable settle and slew-limited move for the current channel
  always_comb begin
    pin_low = 1'b0;
    for (int k = 0; k < sslp_pkg::PIN_BITS; k++) begin
      if (int'(chan_idx) == k) begin
        pin_low = pins_r[k];
      end
    end
    en_new = enabled_r[chan_idx];
    wr_c   = 1'b0;
    calc_c = 1'b0;
    if (enabled_r[chan_idx] != request_r[chan_idx]) begin
      if (!request_r[chan_idx]) begin
        if (pin_low) begin
          en_new = 1'b0;
          wr_c   = 1'b1;
        end
      end else begin
        en_new = 1'b1;
      end
    end
    err      = {{7{target_r[chan_idx][11]}}, target_r[chan_idx]} * sslp_pkg::POS_SCALE
               - {pos_r[chan_idx][17], pos_r[chan_idx]};
    mag      = err[18] ? -err : err;
    rate_ext = {7'b0, rate_r[chan_idx]};
    dw       = err;
    if (rate_ext != '0 && mag > rate_ext) begin
      dw = err[18] ? -rate_ext : rate_ext;
    end
    pos_new = pos_r[chan_idx];
    if (en_new && dw != '0) begin
      pos_new = 18'(({pos_r[chan_idx][17], pos_r[chan_idx]}) + dw);
      wr_c    = 1'b1;
      calc_c  = 1'b1;
    end
  end

  // Channel state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        enabled_r[c] <= 1'b0;
        request_r[c] <= 1'b0;
        target_r[c]  <= '0;
        rate_r[c]    <= '0;
        pos_r[c]     <= '0;
      end
      pins_r <= '0;
    end else begin
      if (cmd.set_wr && int'(in_channel) < CHANNELS) begin
        target_r[CW'(in_channel)]  <= tgt_sat;
        rate_r[CW'(in_channel)]    <= in_step_limit;
        request_r[CW'(in_channel)] <= in_enable_req;
      end
      if (cmd.tick_load) begin
        pins_r <= in_pins_low;
      end
      if (cmd.step) begin
        enabled_r[chan_idx] <= en_new;
        pos_r[chan_idx]     <= pos_new;
      end
    end
  end

  // Step result capture
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      wr_r    <= wr_c;
      calc_r  <= calc_c;
      pos_s_r <= pos_new;
    end
  end

  // position / 100 by reciprocal on the magnitude, sign kept aside
  assign abs_pos = pos_s_r[17] ? 17'(-pos_s_r) : pos_s_r[16:0];

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      neg_r   <= pos_s_r[17];
      prod1_r <= 35'(abs_pos) * 35'(sslp_pkg::RECIP_100);
    end
  end

  assign quot = prod1_r[sslp_pkg::RECIP_SHIFT +: 11];

  // quotient * gain
  always_ff @(posedge clk) begin
    if (cmd.gain) begin
      prod2_r <= 23'(quot) * 23'(gain_r);
    end
  end

  // /2 then /512 toward zero is >>10 on the magnitude; add midpoint and clamp
  always_comb begin
    mag_pwm = prod2_r[22:10];
    pwm_raw = neg_r ? ($signed({3'b0, mid_r}) - $signed({2'b0, mag_pwm}))
                    : ($signed({3'b0, mid_r}) + $signed({2'b0, mag_pwm}));
    if (pwm_raw < sslp_pkg::PWM_MIN) begin
      pwm_clamped = 12'(sslp_pkg::PWM_MIN);
    end else if (pwm_raw > sslp_pkg::PWM_MAX) begin
      pwm_clamped = 12'(sslp_pkg::PWM_MAX);
    end else begin
      pwm_clamped = pwm_raw[11:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_channel   <= 3'(chan_idx);
      out_pwm_write <= wr_r;
      out_pwm_value <= calc_r ? pwm_clamped : '0;
      out_last      <= cmd.last;
    end
  end

endmodule

FILE: design/servo_slew_limited_pwm_top.sv
// servo_slew_limited_pwm_top: multi-channel servo ramp generator with PWM output.
// Depends on sslp_pkg, sslp_ctrl and sslp_datapath.
//
//   channel | direction | contents
//   in_     | in        | set item (target, step limit, enable) or tick item (pin levels)
//   out_    | out       | one result per served channel of a tick, channel order
//   cfg_    | in        | pulse gain, pulse midpoint, channels in use
//
// A set item is stored without leaving idle. A tick item walks each served channel
// through step, divide, gain multiply, clamp and result, as the controller walks
// channels one at a time through the shared PWM arithmetic.
// Synchronous active-low reset clears channel state and loads register defaults.
// A stalled result holds the channel walk; no input is taken until a tick ends.
`timescale 1ns / 1ps

module servo_slew_limited_pwm_top #(
  parameter int CHANNELS = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [2:0]         in_channel,
  input  logic signed [11:0] in_target_pos,
  input  logic [11:0]        in_step_limit,
  input  logic               in_enable_req,
  input  logic [4:0]         in_pins_low,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_channel,
  output logic               out_pwm_write,
  output logic [11:0]        out_pwm_value,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_wdata
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NW = $clog2(CHANNELS + 1);

  sslp_pkg::cmd_t cmd;
  logic [CW-1:0]  chan_idx;
  logic [NW-1:0]  n_eff;

  // Sequencer
  sslp_ctrl #(
    .CHANNELS (CHANNELS),
    .CW       (CW),
    .NW       (NW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .n_eff     (n_eff),
    .chan_idx  (chan_idx),
    .cmd       (cmd)
  );

  // Channel state and arithmetic
  sslp_datapath #(
    .CHANNELS (CHANNELS),
    .CW       (CW),
    .NW       (NW)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .chan_idx      (chan_idx),
    .n_eff         (n_eff),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_channel    (in_channel),
    .in_target_pos (in_target_pos),
    .in_step_limit (in_step_limit),
    .in_enable_req (in_enable_req),
    .in_pins_low   (in_pins_low),
    .out_channel   (out_channel),
    .out_pwm_write (out_pwm_write),
    .out_pwm_value (out_pwm_value),
    .out_last      (out_last)
  );

endmodule

FILE: tb/servo_slew_limited_pwm_top_tb.sv
// servo_slew_limited_pwm_top_tb: self-checking bench for the servo ramp and PWM block.
// Depends on sslp_pkg and servo_slew_limited_pwm_top; keeps its own servo model to
// predict every result item and compares each one field by field.
`timescale 1ns / 1ps

module servo_slew_limited_pwm_top_tb;

  localparam int NUM_CH        = 5;
  localparam int SETTLE_CYCLES = 40;
  localparam int RUN_LIMIT_NS  = 2000000;
  localparam logic [1:0] CFG_NONE = 2'd3; // unmapped register index

  // One input item and one result item
  typedef struct packed {
    logic               op;
    logic [2:0]         channel;
    logic signed [11:0] target_pos;
    logic [11:0]        step_limit;
    logic               enable_req;
    logic [4:0]         pins_low;
  } servo_item_t;

  typedef struct packed {
    logic [2:0]  chan;
    logic        wr;
    logic [11:0] value;
    logic        last;
  } pwm_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_op;
  logic [2:0]         in_channel;
  logic signed [11:0] in_target_pos;
  logic [11:0]        in_step_limit;
  logic               in_enable_req;
  logic [4:0]         in_pins_low;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         out_channel;
  logic               out_pwm_write;
  logic [11:0]        out_pwm_value;
  logic               out_last;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [11:0]        cfg_wdata;

  servo_slew_limited_pwm_top #(.CHANNELS(NUM_CH)) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_channel    (in_channel),
    .in_target_pos (in_target_pos),
    .in_step_limit (in_step_limit),
    .in_enable_req (in_enable_req),
    .in_pins_low   (in_pins_low),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_channel   (out_channel),
    .out_pwm_write (out_pwm_write),
    .out_pwm_value (out_pwm_value),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // Servo model state
  logic [11:0] gain_cfg = sslp_pkg::GAIN_RST;
  logic [11:0] mid_cfg  = sslp_pkg::MID_RST;
  logic [2:0]  in_use_cfg = sslp_pkg::CHAN_USE_RST;
  bit          chan_on  [NUM_CH];
  bit          chan_req [NUM_CH];
  int          chan_tgt [NUM_CH];
  int          chan_rate[NUM_CH];
  int          chan_pos [NUM_CH];

  pwm_result_t pending_pwm_q[$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("[servo_slew_limited_pwm_top] ERROR");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Clamped PWM for a position in 1/100 units
  function automatic logic [11:0] pwm_from_position(input int pos);
    int q;
    int v;
    q = pos / 100;
    v = ((q * int'(gain_cfg)) / 2) / 512 + int'(mid_cfg);
    if (v < 200) v = 200;
    else if (v > 3250) v = 3250;
    return 12'(v);
  endfunction

  // Apply one accepted item to the model and queue the PWM results it causes
  task automatic advance_servos(input servo_item_t it);
    int n;
    int t;
    int e;
    int dw;
    int mag;
    pwm_result_t res;
    if (it.op == sslp_pkg::OP_SET) begin
      if (it.channel < NUM_CH) begin
        t = $signed(it.target_pos);
        if (t < -1024) t = -1024;
        else if (t > 1024) t = 1024;
        chan_tgt[it.channel]  = t;
        chan_rate[it.channel] = int'(it.step_limit);
        chan_req[it.channel]  = it.enable_req;
      end
    end else begin
      n = (in_use_cfg > NUM_CH) ? NUM_CH : int'(in_use_cfg);
      for (int i = 0; i < n; i++) begin
        res = '0;
        res.chan = 3'(i);
        res.last = (i + 1 == n);
        // enable at once, disable only on a low pin
        if (chan_on[i] != chan_req[i]) begin
          if (!chan_req[i]) begin
            if (it.pins_low[i]) begin
              chan_on[i] = 1'b0;
              res.wr     = 1'b1;
              res.value  = '0;
            end
          end else begin
            chan_on[i] = 1'b1;
          end
        end
        // slew toward target
        if (chan_on[i]) begin
          e   = chan_tgt[i] * 100 - chan_pos[i];
          dw  = e;
          mag = (e < 0) ? -e : e;
          if (chan_rate[i] > 0 && mag > chan_rate[i]) dw = (e > 0) ? chan_rate[i] : -chan_rate[i];
          if (dw != 0) begin
            chan_pos[i] += dw;
            res.wr    = 1'b1;
            res.value = pwm_from_position(chan_pos[i]);
          end
        end
        pending_pwm_q.push_back(res);
      end
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    pwm_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pwm_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result ch=%0d", out_channel));
      end else begin
        want = pending_pwm_q.pop_front();
        if (out_channel !== want.chan)
          flag_mismatch($sformatf("channel %0d, want %0d", out_channel, want.chan));
        if (out_pwm_write !== want.wr)
          flag_mismatch($sformatf("ch%0d pwm_write %0b, want %0b", want.chan,
                                  out_pwm_write, want.wr));
        if (out_pwm_value !== want.value)
          flag_mismatch($sformatf("ch%0d pwm_value %0d, want %0d", want.chan,
                                  out_pwm_value, want.value));
        if (out_last !== want.last)
          flag_mismatch($sformatf("ch%0d last %0b, want %0b", want.chan,
                                  out_last, want.last));
      end
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one item, with random idle cycles ahead of it
  task automatic send_item(input servo_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_op         = it.op;
    in_channel    = it.channel;
    in_target_pos = it.target_pos;
    in_step_limit = it.step_limit;
    in_enable_req = it.enable_req;
    in_pins_low   = it.pins_low;
    in_valid      = 1'b1;
    do @(posedge clk); while (!in_ready);
    advance_servos(it);
  endtask

  // Stop sending and let every pending result drain
  task automatic settle_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pwm_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [11:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    case (idx)
      sslp_pkg::CFG_PULSE_GAIN: gain_cfg   = val;
      sslp_pkg::CFG_PULSE_MID:  mid_cfg    = val;
      sslp_pkg::CFG_CHAN_USE:   in_use_cfg = val[2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic servo_item_t set_item(input int ch, input int tgt, input int lim,
                                           input bit en);
    servo_item_t it;
    it            = '0;
    it.op         = sslp_pkg::OP_SET;
    it.channel    = 3'(ch);
    it.target_pos = 12'(tgt);
    it.step_limit = 12'(lim);
    it.enable_req = en;
    return it;
  endfunction

  function automatic servo_item_t tick_item(input logic [4:0] pins);
    servo_item_t it;
    it          = '0;
    it.op       = sslp_pkg::OP_TICK;
    it.pins_low = pins;
    return it;
  endfunction

  // Mostly valid sets and ticks, some out-of-range channels and targets
  function automatic servo_item_t random_servo_item();
    servo_item_t it;
    int pick;
    it.channel    = 3'($urandom);
    it.target_pos = 12'($urandom);
    it.step_limit = 12'($urandom);
    it.enable_req = 1'($urandom);
    it.pins_low   = 5'($urandom);
    if ($urandom_range(99) < 45) begin
      it.op = sslp_pkg::OP_SET;
      if ($urandom_range(9) != 0) it.channel = 3'($urandom_range(4));
      if ($urandom_range(9) < 7) it.target_pos = 12'(int'($urandom_range(2048)) - 1024);
      pick = $urandom_range(9);
      if (pick < 3) it.step_limit = '0;
      else if (pick < 8) it.step_limit = 12'($urandom_range(400, 1));
      it.enable_req = ($urandom_range(99) < 85);
    end else begin
      it.op = sslp_pkg::OP_TICK;
    end
    return it;
  endfunction

  // Nothing enabled: every served channel reports no write
  task automatic test_idle_outputs();
    send_item(tick_item(5'b00000));
  endtask

  // Target saturation, ignored channels, unlimited and limited steps
  task automatic test_target_range();
    send_item(set_item(0, 2047, 0, 1'b1));
    send_item(set_item(1, -2048, 0, 1'b1));
    send_item(set_item(2, 1024, 4095, 1'b1));
    send_item(set_item(3, -1024, 1, 1'b1));
    send_item(set_item(4, 0, 0, 1'b1));
    send_item(set_item(5, 500, 0, 1'b0));
    send_item(set_item(6, -500, 7, 1'b1));
    send_item(set_item(7, 1, 4095, 1'b1));
    send_item(tick_item(5'b00000));
    send_item(tick_item(5'b11111));
  endtask

  // A disable waits for its pin to read low, then writes zero
  task automatic test_deferred_disable();
    send_item(set_item(0, 1024, 0, 1'b0));
    send_item(tick_item(5'b00000));
    send_item(tick_item(5'b11110));
    send_item(tick_item(5'b11111));
  endtask

  // Channel counts of zero and above the channel count, PWM clamps at both ends
  task automatic test_config_extremes();
    settle_block();
    cfg_write(sslp_pkg::CFG_CHAN_USE, 12'd0);
    send_item(tick_item(5'b10101));
    settle_block();
    cfg_write(sslp_pkg::CFG_CHAN_USE, 12'd7);
    send_item(tick_item(5'b01010));
    settle_block();
    cfg_write(sslp_pkg::CFG_CHAN_USE, 12'd6);
    send_item(tick_item(5'b00000));
    settle_block();
    cfg_write(sslp_pkg::CFG_CHAN_USE, 12'd1);
    cfg_write(sslp_pkg::CFG_PULSE_GAIN, 12'd4095);
    cfg_write(sslp_pkg::CFG_PULSE_MID, 12'd4095);
    send_item(set_item(0, 1, 0, 1'b1));
    send_item(tick_item(5'b00000));
    settle_block();
    cfg_write(sslp_pkg::CFG_PULSE_MID, 12'd0);
    cfg_write(CFG_NONE, 12'hFFF);
    send_item(set_item(0, -1024, 0, 1'b1));
    send_item(tick_item(5'b00000));
    settle_block();
    cfg_write(sslp_pkg::CFG_PULSE_GAIN, 12'd0);
    send_item(set_item(0, 5, 0, 1'b1));
    send_item(tick_item(5'b00000));
    settle_block();
    cfg_write(sslp_pkg::CFG_PULSE_GAIN, sslp_pkg::GAIN_RST);
    cfg_write(sslp_pkg::CFG_PULSE_MID, sslp_pkg::MID_RST);
    cfg_write(sslp_pkg::CFG_CHAN_USE, 12'(sslp_pkg::CHAN_USE_RST));
  endtask

  // Random sets and ticks under one idling pattern and one random setting
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    settle_block();
    cfg_write(sslp_pkg::CFG_PULSE_GAIN, 12'($urandom));
    cfg_write(sslp_pkg::CFG_PULSE_MID, 12'($urandom));
    cfg_write(sslp_pkg::CFG_CHAN_USE,
              ($urandom_range(9) < 6) ? 12'd5 : 12'($urandom_range(7)));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_item(random_servo_item());
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = sslp_pkg::OP_SET;
    in_channel    = '0;
    in_target_pos = '0;
    in_step_limit = '0;
    in_enable_req = 1'b0;
    in_pins_low   = '0;
    cfg_we        = 1'b0;
    cfg_index     = sslp_pkg::CFG_PULSE_GAIN;
    cfg_wdata     = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      chan_on[i]   = 1'b0;
      chan_req[i]  = 1'b0;
      chan_tgt[i]  = 0;
      chan_rate[i] = 0;
      chan_pos[i]  = 0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_outputs();
    test_target_range();
    test_deferred_disable();
    test_config_extremes();
    test_random_traffic(0, 0, 62);
    test_random_traffic(59, 0, 62);
    test_random_traffic(0, 59, 62);
    test_random_traffic(13, 13, 62);

    settle_block();
    if (mismatch_count == 0) begin
      $display("[servo_slew_limited_pwm_top] OK");
    end else begin
      $display("[servo_slew_limited_pwm_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: servo_slew_limited_pwm_top.f
design/sslp_pkg.sv
design/sslp_ctrl.sv
design/sslp_datapath.sv
design/servo_slew_limited_pwm_top.sv
tb/servo_slew_limited_pwm_top_tb.sv
